/* design/dbg_pkg.sv */
`default_nettype none
package dbg_pkg;

  localparam int unsigned THR_W      = 16;
  localparam int unsigned MINNB_W    = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned NOUT_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NB  = 1'b1;

  localparam logic [THR_W-1:0]   IOU_THR_RST = 16'd19661;
  localparam logic [MINNB_W-1:0] MIN_NB_RST  = 7'd3;

  typedef struct packed {
    logic done;
    logic hit;
  } iou_res_t;

endpackage
`default_nettype wire

/* design/dbg_if.sv */
`default_nettype none
interface dbg_box_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;
  logic                  list_end;

  modport source (output valid, box_x, box_y, box_width, box_height, list_end, input ready);
  modport sink   (input valid, box_x, box_y, box_width, box_height, list_end, output ready);
endinterface

interface dbg_res_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [COORD_BITS-1:0] out_width;
  logic [COORD_BITS-1:0] out_height;
  logic                  out_valid;
  logic                  out_last;
  logic                  overflow;

  modport source (output valid, out_x, out_y, out_width, out_height, out_valid, out_last,
                  overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_width, out_height, out_valid, out_last,
                  overflow, output ready);
endinterface
`default_nettype wire

/* design/dbg_store.sv */
`default_nettype none
module dbg_store #(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned AW = $clog2(MAX_BOXES),
  localparam int unsigned BW = 4 * COORD_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          box_we_i,
  input  wire logic [AW-1:0] box_waddr_i,
  input  wire logic [BW-1:0] box_wdata_i,
  input  wire logic          ba_re_i,
  input  wire logic [AW-1:0] ba_raddr_i,
  output logic      [BW-1:0] ba_rdata_o,
  input  wire logic          bb_re_i,
  input  wire logic [AW-1:0] bb_raddr_i,
  output logic      [BW-1:0] bb_rdata_o,
  input  wire logic          tk_we_i,
  input  wire logic [AW-1:0] tk_waddr_i,
  input  wire logic          tk_wdata_i,
  input  wire logic          tk_re_i,
  input  wire logic [AW-1:0] tk_raddr_i,
  output logic               tk_rdata_o,
  input  wire logic          mb_we_i,
  input  wire logic [AW-1:0] mb_waddr_i,
  input  wire logic [AW-1:0] mb_wdata_i,
  input  wire logic          mb_re_i,
  input  wire logic [AW-1:0] mb_raddr_i,
  output logic      [AW-1:0] mb_rdata_o
);

  logic [BW-1:0] box_mem [MAX_BOXES];
  logic          tk_mem  [MAX_BOXES];
  logic [AW-1:0] mb_mem  [MAX_BOXES];

  always_ff @(posedge clk_i) begin
    if (box_we_i) begin
      box_mem[box_waddr_i] <= box_wdata_i;
    end
    if (ba_re_i) begin
      ba_rdata_o <= box_mem[ba_raddr_i];
    end
    if (bb_re_i) begin
      bb_rdata_o <= box_mem[bb_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tk_we_i) begin
      tk_mem[tk_waddr_i] <= tk_wdata_i;
    end
    if (tk_re_i) begin
      tk_rdata_o <= tk_mem[tk_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mb_we_i) begin
      mb_mem[mb_waddr_i] <= mb_wdata_i;
    end
    if (mb_re_i) begin
      mb_rdata_o <= mb_mem[mb_raddr_i];
    end
  end

endmodule
`default_nettype wire

/* design/dbg_iou.sv */
`default_nettype none
module dbg_iou #(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned C  = COORD_BITS,
  localparam int unsigned PW = 2 * COORD_BITS + 17
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [C-1:0]          ax_i,
  input  wire logic [C-1:0]          ay_i,
  input  wire logic [C-1:0]          aw_i,
  input  wire logic [C-1:0]          ah_i,
  input  wire logic [C-1:0]          bx_i,
  input  wire logic [C-1:0]          by_i,
  input  wire logic [C-1:0]          bw_i,
  input  wire logic [C-1:0]          bh_i,
  input  wire logic [dbg_pkg::THR_W-1:0] thr_i,
  output dbg_pkg::iou_res_t          res_o
);
  import dbg_pkg::*;

  logic [3:0]     v_q;
  logic [C:0]     ea_x, eb_x, ea_y, eb_y, min_x, max_x, min_y, max_y;
  logic [C:0]     ix_full, iy_full;
  logic [C-1:0]   ix_q, iy_q, aw_q, ah_q, bw_q, bh_q;
  logic [2*C-1:0] inter_q, aa_q, ab_q, inter3_q;
  logic [2*C:0]   uni_q;
  logic [PW-1:0]  prod_q, lhs_q;
  logic           nz_q, hit_q, done_q;

  always_comb begin
    ea_x  = {1'b0, ax_i} + {1'b0, aw_i};
    eb_x  = {1'b0, bx_i} + {1'b0, bw_i};
    ea_y  = {1'b0, ay_i} + {1'b0, ah_i};
    eb_y  = {1'b0, by_i} + {1'b0, bh_i};
    min_x = (ea_x < eb_x) ? ea_x : eb_x;
    min_y = (ea_y < eb_y) ? ea_y : eb_y;
    max_x = (ax_i > bx_i) ? {1'b0, ax_i} : {1'b0, bx_i};
    max_y = (ay_i > by_i) ? {1'b0, ay_i} : {1'b0, by_i};
    ix_full = (min_x > max_x) ? (min_x - max_x) : '0;
    iy_full = (min_y > max_y) ? (min_y - max_y) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[2:0], start_i};
      done_q <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    ix_q     <= ix_full[C-1:0];
    iy_q     <= iy_full[C-1:0];
    aw_q     <= aw_i;
    ah_q     <= ah_i;
    bw_q     <= bw_i;
    bh_q     <= bh_i;
    inter_q  <= ix_q * iy_q;
    aa_q     <= aw_q * ah_q;
    ab_q     <= bw_q * bh_q;
    uni_q    <= {1'b0, aa_q} + {1'b0, ab_q} - {1'b0, inter_q};
    inter3_q <= inter_q;
    prod_q   <= PW'(thr_i) * PW'(uni_q);
    lhs_q    <= {1'b0, inter3_q, 16'b0};
    nz_q     <= (uni_q != '0);
    hit_q    <= nz_q && (lhs_q > prod_q);
  end

  assign res_o.done = done_q;
  assign res_o.hit  = hit_q;

endmodule
`default_nettype wire

/* design/dbg_div.sv */
`default_nettype none
module dbg_div #(
  parameter int unsigned WN = 19,
  parameter int unsigned WD = 7,
  localparam int unsigned CNT_W = $clog2(WN + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [WN-1:0] num_i,
  input  wire logic [WD-1:0] den_i,
  output logic               done_o,
  output logic      [WN-1:0] quo_o
);

  logic [WN-1:0]    q_q;
  logic [WD:0]      r_q, r_sh;
  logic [WD-1:0]    d_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    r_sh = {r_q[WD-1:0], q_q[WN-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WN);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      if (r_sh >= {1'b0, d_q}) begin
        r_q <= r_sh - {1'b0, d_q};
        q_q <= {q_q[WN-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[WN-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule
`default_nettype wire

/* design/detection_box_grouping_top.sv */
// Loading: one box a cycle; the list end starts grouping and input stalls until the last
// result is in the output register.
// Grouping: each box-member IoU test runs through the box store reads and the five-stage IoU
// pipeline. Each emitted group sums its members' boxes, then divides each of the four sums
// by the member count in the serial divider.
// Reset (asynchronous, active low) clears control, counts and config to defaults; no memory pass.
`default_nettype none
module detection_box_grouping_top #(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dbg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dbg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  dbg_box_if.sink                                box_i,
  dbg_res_if.source                              res_o
);
  import dbg_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned AW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned BW = 4 * C;
  localparam int unsigned SW = C + CW;

  typedef enum logic [4:0] {
    S_LOAD, S_I, S_I_W, S_J, S_J_W, S_K, S_K_M, S_K_B, S_K_I,
    S_DONE, S_S, S_S_M, S_S_B, S_DIV, S_DIV_W, S_PUT, S_FIN
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  cnt_q, i_q, j_q, k_q, size_q;
  logic [NOUT_W-1:0] nout_q;
  logic           ovf_q, pend_q;
  logic [THR_W-1:0]   thr_q;
  logic [MINNB_W-1:0] min_nb_q;
  logic [SW-1:0]  sum_q [4];
  logic [C-1:0]   res_q [4];
  logic [C-1:0]   pend_box_q [4];
  logic [1:0]     f_q;
  logic           out_vld_q, out_ok_q, out_last_q, out_ovf_q;
  logic [C-1:0]   out_box_q [4];

  logic          acc, full, i_end, slot_free, out_load;
  logic          box_we, ba_re, bb_re, tk_we, tk_wdata, tk_re, mb_we, mb_re;
  logic [AW-1:0] ba_raddr, bb_raddr, tk_waddr, tk_raddr, mb_waddr, mb_wdata, mb_raddr;
  logic [BW-1:0] ba_rdata, bb_rdata;
  logic          tk_rdata;
  logic [AW-1:0] mb_rdata;
  logic          iou_start, div_start, div_done;
  logic [SW-1:0] div_quo;
  iou_res_t      iou_res;

  assign box_i.ready = (state_q == S_LOAD);
  assign acc         = box_i.valid && box_i.ready;
  assign full        = (cnt_q == CW'(MAX_BOXES));
  assign i_end       = (i_q >= cnt_q) || (nout_q == NOUT_W'(RESULT_CAP));
  assign slot_free   = !out_vld_q || res_o.ready;
  assign out_load    = ((state_q == S_PUT) && pend_q && slot_free)
                    || ((state_q == S_FIN) && slot_free);

  always_comb begin
    box_we    = 1'b0;
    ba_re     = 1'b0;
    bb_re     = 1'b0;
    tk_we     = 1'b0;
    tk_wdata  = 1'b0;
    tk_re     = 1'b0;
    mb_we     = 1'b0;
    mb_re     = 1'b0;
    ba_raddr  = j_q[AW-1:0];
    bb_raddr  = mb_rdata;
    tk_waddr  = cnt_q[AW-1:0];
    tk_raddr  = i_q[AW-1:0];
    mb_waddr  = size_q[AW-1:0];
    mb_wdata  = j_q[AW-1:0];
    mb_raddr  = k_q[AW-1:0];
    iou_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_LOAD: begin
        box_we = acc && !full;
        tk_we  = acc && !full;
      end
      S_I: begin
        tk_re = !i_end;
      end
      S_I_W: begin
        tk_we    = !tk_rdata;
        tk_waddr = i_q[AW-1:0];
        tk_wdata = 1'b1;
        mb_we    = !tk_rdata;
        mb_waddr = '0;
        mb_wdata = i_q[AW-1:0];
      end
      S_J: begin
        tk_re    = (j_q < cnt_q);
        tk_raddr = j_q[AW-1:0];
        ba_re    = (j_q < cnt_q);
      end
      S_K:     mb_re = (k_q < size_q);
      S_K_M:   bb_re = 1'b1;
      S_K_B:   iou_start = 1'b1;
      S_K_I: begin
        tk_we    = iou_res.done && iou_res.hit;
        tk_waddr = j_q[AW-1:0];
        tk_wdata = 1'b1;
        mb_we    = iou_res.done && iou_res.hit;
      end
      S_S:     mb_re = (k_q < size_q);
      S_S_M:   bb_re = 1'b1;
      S_DIV:   div_start = 1'b1;
      default: begin
      end
    endcase
  end

  dbg_store #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(C)) u_store (
    .clk_i       (clk_i),
    .box_we_i    (box_we),
    .box_waddr_i (cnt_q[AW-1:0]),
    .box_wdata_i ({box_i.box_x, box_i.box_y, box_i.box_width, box_i.box_height}),
    .ba_re_i     (ba_re),
    .ba_raddr_i  (ba_raddr),
    .ba_rdata_o  (ba_rdata),
    .bb_re_i     (bb_re),
    .bb_raddr_i  (bb_raddr),
    .bb_rdata_o  (bb_rdata),
    .tk_we_i     (tk_we),
    .tk_waddr_i  (tk_waddr),
    .tk_wdata_i  (tk_wdata),
    .tk_re_i     (tk_re),
    .tk_raddr_i  (tk_raddr),
    .tk_rdata_o  (tk_rdata),
    .mb_we_i     (mb_we),
    .mb_waddr_i  (mb_waddr),
    .mb_wdata_i  (mb_wdata),
    .mb_re_i     (mb_re),
    .mb_raddr_i  (mb_raddr),
    .mb_rdata_o  (mb_rdata)
  );

  dbg_iou #(.COORD_BITS(C)) u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iou_start),
    .ax_i    (ba_rdata[4*C-1:3*C]),
    .ay_i    (ba_rdata[3*C-1:2*C]),
    .aw_i    (ba_rdata[2*C-1:C]),
    .ah_i    (ba_rdata[C-1:0]),
    .bx_i    (bb_rdata[4*C-1:3*C]),
    .by_i    (bb_rdata[3*C-1:2*C]),
    .bw_i    (bb_rdata[2*C-1:C]),
    .bh_i    (bb_rdata[C-1:0]),
    .thr_i   (thr_q),
    .res_o   (iou_res)
  );

  dbg_div #(.WN(SW), .WD(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q[f_q]),
    .den_i   (size_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= IOU_THR_RST;
      min_nb_q <= MIN_NB_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IOU_THR: thr_q    <= cfg_data_i[THR_W-1:0];
        CFG_MIN_NB:  min_nb_q <= cfg_data_i[MINNB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      size_q     <= '0;
      nout_q     <= '0;
      f_q        <= '0;
      ovf_q      <= 1'b0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_ok_q   <= 1'b0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (acc) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
            if (box_i.list_end) begin
              i_q     <= '0;
              nout_q  <= '0;
              pend_q  <= 1'b0;
              state_q <= S_I;
            end
          end
        end
        S_I: state_q <= i_end ? S_FIN : S_I_W;
        S_I_W: begin
          if (tk_rdata) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_I;
          end else begin
            size_q  <= CW'(1);
            j_q     <= i_q + 1'b1;
            state_q <= S_J;
          end
        end
        S_J: state_q <= (j_q < cnt_q) ? S_J_W : S_DONE;
        S_J_W: begin
          if (tk_rdata) begin
            j_q     <= j_q + 1'b1;
            state_q <= S_J;
          end else begin
            k_q     <= '0;
            state_q <= S_K;
          end
        end
        S_K: begin
          if (k_q < size_q) begin
            state_q <= S_K_M;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_J;
          end
        end
        S_K_M: state_q <= S_K_B;
        S_K_B: state_q <= S_K_I;
        S_K_I: begin
          if (iou_res.done) begin
            if (iou_res.hit) begin
              size_q  <= size_q + 1'b1;
              j_q     <= j_q + 1'b1;
              state_q <= S_J;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_K;
            end
          end
        end
        S_DONE: begin
          if (32'(size_q) >= 32'(min_nb_q)) begin
            k_q <= '0;
            for (int n = 0; n < 4; n++) begin
              sum_q[n] <= '0;
            end
            state_q <= S_S;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_I;
          end
        end
        S_S: begin
          if (k_q < size_q) begin
            state_q <= S_S_M;
          end else begin
            f_q     <= '0;
            state_q <= S_DIV;
          end
        end
        S_S_M: state_q <= S_S_B;
        S_S_B: begin
          sum_q[0] <= sum_q[0] + SW'(bb_rdata[4*C-1:3*C]);
          sum_q[1] <= sum_q[1] + SW'(bb_rdata[3*C-1:2*C]);
          sum_q[2] <= sum_q[2] + SW'(bb_rdata[2*C-1:C]);
          sum_q[3] <= sum_q[3] + SW'(bb_rdata[C-1:0]);
          k_q      <= k_q + 1'b1;
          state_q  <= S_S;
        end
        S_DIV: state_q <= S_DIV_W;
        S_DIV_W: begin
          if (div_done) begin
            res_q[f_q] <= div_quo[C-1:0];
            f_q        <= f_q + 1'b1;
            state_q    <= (f_q == 2'd3) ? S_PUT : S_DIV;
          end
        end
        S_PUT: begin
          if (!pend_q || slot_free) begin
            if (pend_q) begin
              out_ok_q   <= 1'b1;
              out_last_q <= 1'b0;
              out_ovf_q  <= ovf_q;
              out_box_q  <= pend_box_q;
            end
            pend_q     <= 1'b1;
            pend_box_q <= res_q;
            nout_q     <= nout_q + 1'b1;
            i_q        <= i_q + 1'b1;
            state_q    <= S_I;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_ok_q   <= pend_q;
            out_last_q <= 1'b1;
            out_ovf_q  <= ovf_q;
            for (int n = 0; n < 4; n++) begin
              out_box_q[n] <= pend_q ? pend_box_q[n] : '0;
            end
            pend_q  <= 1'b0;
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.out_x      = out_box_q[0];
  assign res_o.out_y      = out_box_q[1];
  assign res_o.out_width  = out_box_q[2];
  assign res_o.out_height = out_box_q[3];
  assign res_o.out_valid  = out_ok_q;
  assign res_o.out_last   = out_last_q;
  assign res_o.overflow   = out_ovf_q;

endmodule
`default_nettype wire

/* design/dbg_checker.sv */
`default_nettype none
module dbg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_end_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_ok_i,
  input wire logic out_last_i,
  input wire logic out_ovf_i
);

  a_invalid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ok_i |-> out_last_i)
    else $error("no-group result without last flag");

  a_end_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_i |=> !in_ready_i)
    else $error("input still ready after list end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ok_i) && $stable(out_last_i)
      && $stable(out_ovf_i))
    else $error("stalled result changed");

endmodule

bind detection_box_grouping_top dbg_checker u_dbg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (box_i.valid),
  .in_ready_i  (box_i.ready),
  .in_end_i    (box_i.list_end),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_ok_i    (res_o.out_valid),
  .out_last_i  (res_o.out_last),
  .out_ovf_i   (res_o.overflow)
);
`default_nettype wire

/* verif/tb_detection_box_grouping_top.sv */
`default_nettype none
module tb_detection_box_grouping_top;
  import dbg_pkg::*;

  localparam int unsigned CB    = 12;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned LIMIT = 800000;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
  } box_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
    logic          valid;
    logic          last;
    logic          ovf;
  } grp_res_t;

  typedef struct {
    box_t     b;
    bit       list_end;
    bit       typed;
    grp_res_t res;
  } stim_row_t;

  typedef enum int {LIST_NOISE, LIST_CLUSTER, LIST_SAME} list_kind_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dbg_box_if #(.COORD_BITS(CB)) bi ();
  dbg_res_if #(.COORD_BITS(CB)) ro ();

  detection_box_grouping_top #(.MAX_BOXES(DEPTH), .COORD_BITS(CB)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .box_i     (bi),
    .res_o     (ro)
  );

  logic [THR_W-1:0]   thr_q;
  logic [MINNB_W-1:0] min_nb_q;
  box_t               list_q[$];
  bit                 list_ovf;
  grp_res_t           group_q[$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 items_sent;
  bit                 calm;
  bit                 hold_go;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit iou_hit(box_t a, box_t b);
    longint ix, iy, inter, uni;
    ix = ((a.x + 64'(a.w) < b.x + 64'(b.w)) ? longint'(a.x) + a.w : longint'(b.x) + b.w)
         - ((a.x > b.x) ? longint'(a.x) : longint'(b.x));
    iy = ((a.y + 64'(a.h) < b.y + 64'(b.h)) ? longint'(a.y) + a.h : longint'(b.y) + b.h)
         - ((a.y > b.y) ? longint'(a.y) : longint'(b.y));
    if (ix < 0) ix = 0;
    if (iy < 0) iy = 0;
    inter = ix * iy;
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    if (uni <= 0) return 1'b0;
    return inter * 65536 > longint'(thr_q) * uni;
  endfunction

  task automatic group_boxes();
    bit       taken[DEPTH];
    int       members[DEPTH];
    int       n, sz, nout;
    longint   sx, sy, sw, sh;
    grp_res_t r;
    n = list_q.size();
    nout = 0;
    foreach (taken[i]) taken[i] = 1'b0;
    for (int i = 0; i < n && nout < RESULT_CAP; i++) begin
      if (!taken[i]) begin
        taken[i] = 1'b1;
        members[0] = i;
        sz = 1;
        for (int j = i + 1; j < n; j++) begin
          if (!taken[j]) begin
            for (int k = 0; k < sz; k++) begin
              if (iou_hit(list_q[j], list_q[members[k]])) begin
                members[sz++] = j;
                taken[j] = 1'b1;
                break;
              end
            end
          end
        end
        if (sz >= min_nb_q) begin
          sx = 0; sy = 0; sw = 0; sh = 0;
          for (int k = 0; k < sz; k++) begin
            sx += list_q[members[k]].x;
            sy += list_q[members[k]].y;
            sw += list_q[members[k]].w;
            sh += list_q[members[k]].h;
          end
          r = '{x: CB'(sx / sz), y: CB'(sy / sz), w: CB'(sw / sz), h: CB'(sh / sz),
                valid: 1'b1, last: 1'b0, ovf: list_ovf};
          group_q = {group_q, r};
          nout++;
        end
      end
    end
    if (nout == 0) begin
      r = '{x: '0, y: '0, w: '0, h: '0, valid: 1'b0, last: 1'b1, ovf: list_ovf};
      group_q = {group_q, r};
    end else begin
      group_q[$].last = 1'b1;
    end
    list_q.delete();
    list_ovf = 1'b0;
  endtask

  task automatic send_box(box_t b, bit list_end, bit typed = 1'b0, grp_res_t res = '0);
    int g;
    g = pick_gap();
    if (g > 0) begin
      bi.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    bi.valid      <= 1'b1;
    bi.box_x      <= b.x;
    bi.box_y      <= b.y;
    bi.box_width  <= b.w;
    bi.box_height <= b.h;
    bi.list_end   <= list_end;
    do @(posedge clk_i); while (!bi.ready);
    items_sent++;
    if (list_q.size() < DEPTH) list_q = {list_q, b};
    else list_ovf = 1'b1;
    if (list_end) begin
      if (typed) begin
        group_q = {group_q, res};
        list_q.delete();
        list_ovf = 1'b0;
      end else begin
        group_boxes();
      end
    end
  endtask

  task automatic wait_idle();
    bi.valid <= 1'b0;
    @(posedge clk_i);
    while (group_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    if (idx == CFG_IOU_THR) thr_q = data[THR_W-1:0];
    else min_nb_q = data[MINNB_W-1:0];
  endtask

  task automatic set_config(logic [THR_W-1:0] thr, logic [MINNB_W-1:0] mnb);
    wait_idle();
    write_reg(CFG_IOU_THR, thr);
    write_reg(CFG_MIN_NB, {(CFG_DATA_W - MINNB_W)'($urandom), mnb});
    cfg_we <= 1'b0;
  endtask

  function automatic box_t rand_box();
    return box_t'((4 * CB)'({$urandom, $urandom}));
  endfunction

  function automatic box_t jitter(box_t b);
    box_t j;
    j.x = b.x + CB'($urandom_range(0, 6));
    j.y = b.y + CB'($urandom_range(0, 6));
    j.w = b.w + CB'($urandom_range(0, 6));
    j.h = b.h + CB'($urandom_range(0, 6));
    return j;
  endfunction

  task automatic send_list(int n, list_kind_e kind);
    box_t bases[3];
    box_t b;
    foreach (bases[i]) begin
      bases[i] = rand_box();
      bases[i].w = CB'($urandom_range(8, 600));
      bases[i].h = CB'($urandom_range(8, 600));
    end
    for (int i = 0; i < n; i++) begin
      case (kind)
        LIST_NOISE:   b = rand_box();
        LIST_SAME:    b = bases[0];
        default: begin
          if ($urandom_range(0, 9) == 0) b = rand_box();
          else b = jitter(bases[$urandom_range(0, 2)]);
        end
      endcase
      send_box(b, i == n - 1);
    end
  endtask

  task automatic send_small_lists(int count);
    for (int i = 0; i < count; i++) begin
      send_list($urandom_range(1, 8), ($urandom_range(0, 9) < 7) ? LIST_CLUSTER : LIST_NOISE);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : ready_gen
    int stall;
    int hold;
    bit hold_seen;
    if (!rst_ni) begin
      ro.ready <= 1'b0;
      stall = 0;
      hold = 0;
      hold_seen = 1'b0;
    end else begin
      if (hold_go && !hold_seen) begin
        hold = 500;
        hold_seen = 1'b1;
      end
      if (hold > 0) begin
        ro.ready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        ro.ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        ro.ready <= 1'b0;
        stall = pick_gap();
      end else begin
        ro.ready <= 1'b1;
      end
    end
  end

  task automatic report(string field, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : result_check
    grp_res_t want;
    if (rst_ni && ro.valid && ro.ready) begin
      if (group_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = group_q.pop_front();
        if (ro.out_x !== want.x)          report("out_x", ro.out_x, want.x);
        if (ro.out_y !== want.y)          report("out_y", ro.out_y, want.y);
        if (ro.out_width !== want.w)      report("out_width", ro.out_width, want.w);
        if (ro.out_height !== want.h)     report("out_height", ro.out_height, want.h);
        if (ro.out_valid !== want.valid)  report("out_valid", ro.out_valid, want.valid);
        if (ro.out_last !== want.last)    report("out_last", ro.out_last, want.last);
        if (ro.overflow !== want.ovf)     report("overflow", ro.overflow, want.ovf);
      end
    end
  end

  stim_row_t directed[] = '{
    '{'{12'd7, 12'd9, 12'd100, 12'd50}, 1'b1, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b1, 1'b0}},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, 1'b0, '0},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, 1'b0, '0},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b1, 1'b1,
      '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 1'b0}},
    '{'{12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b1, 1'b0}},
    '{'{12'd0, 12'd0, 12'd100, 12'd100}, 1'b0, 1'b0, '0},
    '{'{12'd10, 12'd10, 12'd100, 12'd100}, 1'b0, 1'b0, '0},
    '{'{12'd2000, 12'd2000, 12'd50, 12'd50}, 1'b0, 1'b0, '0},
    '{'{12'd5, 12'd0, 12'd100, 12'd100}, 1'b0, 1'b0, '0},
    '{'{12'd2002, 12'd2001, 12'd50, 12'd50}, 1'b0, 1'b0, '0},
    '{'{12'd1999, 12'd2000, 12'd50, 12'd50}, 1'b1, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd10, 12'd10}, 1'b0, 1'b0, '0},
    '{'{12'd10, 12'd0, 12'd10, 12'd10}, 1'b0, 1'b0, '0},
    '{'{12'd0, 12'd10, 12'd10, 12'd10}, 1'b1, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd100, 12'd100}, 1'b0, 1'b0, '0},
    '{'{12'd40, 12'd0, 12'd100, 12'd100}, 1'b0, 1'b0, '0},
    '{'{12'd80, 12'd0, 12'd100, 12'd100}, 1'b1, 1'b0, '0},
    '{'{12'd4090, 12'd4000, 12'd4095, 12'd200}, 1'b0, 1'b0, '0},
    '{'{12'd4092, 12'd4001, 12'd4095, 12'd201}, 1'b0, 1'b0, '0},
    '{'{12'd4091, 12'd4002, 12'd4094, 12'd199}, 1'b1, 1'b0, '0}
  };

  initial begin
    items_sent = 0;
    calm       = 1'b0;
    hold_go    = 1'b0;
    list_ovf   = 1'b0;
    thr_q      = IOU_THR_RST;
    min_nb_q   = MIN_NB_RST;
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    bi.valid      = 1'b0;
    bi.box_x      = '0;
    bi.box_y      = '0;
    bi.box_width  = '0;
    bi.box_height = '0;
    bi.list_end   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_box(directed[i].b, directed[i].list_end, directed[i].typed, directed[i].res);
    end

    set_config(16'd0, 7'd0);
    send_small_lists(2);

    set_config(16'hFFFF, 7'd1);
    send_list(24, LIST_NOISE);
    send_small_lists(1);

    set_config(IOU_THR_RST, 7'd64);
    send_list(DEPTH, LIST_SAME);
    send_small_lists(1);

    set_config(THR_W'($urandom), MINNB_W'($urandom_range(1, 3)));
    hold_go = 1'b1;
    send_list(DEPTH + 2, LIST_CLUSTER);
    send_small_lists(1);

    set_config(THR_W'($urandom), 7'd2);
    calm = 1'b1;
    send_small_lists(2);
    calm = 1'b0;
    while (items_sent < 200) send_small_lists(1);

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
